FILE: rtl/core/tep_pkg.sv
// Package for the thermal erosion heightmap: item types, codes and constants.
package tep_pkg;

  localparam int MaxSideDefault    = 256;
  localparam int HeightBitsDefault = 32;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 31;

  localparam logic [CfgIndexBits-1:0] CfgGridWidth  = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgGridHeight = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgTalus      = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgStrength   = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgPassCount  = 3'd4;
  localparam logic [CfgIndexBits-1:0] CfgEightNb    = 3'd5;

  localparam logic [8:0]  GridWidthReset = 9'd256;
  localparam logic [8:0]  GridHeightReset = 9'd256;
  localparam logic [30:0] TalusReset     = 31'd1048576;
  localparam logic [17:0] StrengthReset  = 18'd32768;
  localparam logic [7:0]  PassCountReset = 8'd1;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpRun  = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam logic [11:0] CapLargeGrid  = 12'd524;
  localparam logic [11:0] CapSmallGrid  = 12'd2097;
  localparam int          LargeGridSide = 100;
  localparam logic [18:0] MultOne       = 19'd65536;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        cell_index;
    logic signed [31:0] height_in;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] height_out;
  } out_item_t;

endpackage

FILE: rtl/core/thermal_erosion_heightmap.sv
// Thermal erosion heightmap: height and delta memories with a run sequencer.
// One item is handled at a time; a read passes StRead1 and StRead2 and registers its
// result once the output is free. A run visits each interior cell's 4 or 8 neighbours,
// as the eight-neighbour bit selects, one by one via each memory's single read port.
// After reset all MAX_SIDE * MAX_SIDE words of the delta memory are cleared before
// the first item is accepted; configuration registers reset to their defaults.
module thermal_erosion_heightmap
  import tep_pkg::*;
#(
  parameter int MaxSide    = MaxSideDefault,
  parameter int HeightBits = HeightBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_item_t               out_data_o
);

  localparam int Depth = MaxSide * MaxSide;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = $clog2(MaxSide + 1);
  localparam int HB    = HeightBits;
  localparam logic signed [63:0] HMax = (64'sd1 <<< (HB - 1)) - 64'sd1;
  localparam logic signed [63:0] HMin = -HMax - 64'sd1;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StClear  = 4'd1;
  localparam logic [3:0] StRead1  = 4'd2;
  localparam logic [3:0] StRead2  = 4'd3;
  localparam logic [3:0] StPStart = 4'd4;
  localparam logic [3:0] StCell   = 4'd5;
  localparam logic [3:0] StCellW  = 4'd6;
  localparam logic [3:0] StNb     = 4'd7;
  localparam logic [3:0] StNbW    = 4'd8;
  localparam logic [3:0] StNbM    = 4'd9;
  localparam logic [3:0] StCEnd   = 4'd10;
  localparam logic [3:0] StApplyR = 4'd11;
  localparam logic [3:0] StApplyW = 4'd12;
  localparam logic [3:0] StPEnd   = 4'd13;
  localparam logic [3:0] StDone   = 4'd14;

  function automatic logic [HB-1:0] sat_h(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > HMax) r = HMax;
    else if (v < HMin) r = HMin;
    return r[HB-1:0];
  endfunction

  function automatic logic signed [63:0] sext_h(input logic [HB-1:0] v);
    return 64'(signed'(v));
  endfunction

  // Configuration registers.
  logic [8:0]  grid_width_q, grid_height_q;
  logic [30:0] talus_q;
  logic [17:0] strength_q;
  logic [7:0]  pass_count_q;
  logic        eight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridWidthReset;
      grid_height_q <= GridHeightReset;
      talus_q       <= TalusReset;
      strength_q    <= StrengthReset;
      pass_count_q  <= PassCountReset;
      eight_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGridWidth:  grid_width_q  <= cfg_data_i[8:0];
        CfgGridHeight: grid_height_q <= cfg_data_i[8:0];
        CfgTalus:      talus_q       <= cfg_data_i[30:0];
        CfgStrength:   strength_q    <= cfg_data_i[17:0];
        CfgPassCount:  pass_count_q  <= cfg_data_i[7:0];
        CfgEightNb:    eight_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] w_eff, h_eff;
  assign w_eff = (int'(grid_width_q) > MaxSide) ? SW'(MaxSide) : SW'(grid_width_q);
  assign h_eff = (int'(grid_height_q) > MaxSide) ? SW'(MaxSide) : SW'(grid_height_q);

  // Memories.
  logic [HB-1:0] hmem [Depth];
  logic [31:0]   dmem [Depth];
  logic          h_we, d_we;
  logic [AW-1:0] h_waddr, h_raddr, d_waddr, d_raddr;
  logic [HB-1:0] h_wdata, h_rdata_q;
  logic [31:0]   d_wdata, d_rdata_q;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_rdata_q <= hmem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    d_rdata_q <= dmem[d_raddr];
  end

  // Sequencer state.
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          oor_q, oor_d;
  logic [7:0]    pass_q, pass_d;
  logic [SW-1:0] w_q, w_d, h_q, h_d, col_q, col_d, row_q, row_d;
  logic [AW:0]   n_q, n_d;
  logic [11:0]   cap_q, cap_d;
  logic [AW-1:0] here_q, here_d, there_q, there_d, apply_q, apply_d;
  logic [2:0]    k_q, k_d;
  logic [HB-1:0] h0_q, h0_d;
  logic [31:0]   dacc_q, dacc_d, dthere_q, dthere_d;
  logic          moves_q, moves_d, big_q, big_d;
  logic [11:0]   ex_q, ex_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          out_free, in_acc;
  logic [AW-1:0] there, wa;
  logic signed [63:0] drop, excess, rd_ext;
  logic [18:0]   mult;
  logic [30:0]   prod;
  logic [11:0]   move;
  logic [2:0]    k_last;
  logic [31:0]   rd_word;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wa         = AW'(w_q);
  assign k_last     = eight_q ? 3'd7 : 3'd3;

  always_comb begin
    there = here_q + AW'(1);
    case (k_q)
      3'd0: there = here_q + AW'(1);
      3'd1: there = here_q - AW'(1);
      3'd2: there = here_q + wa;
      3'd3: there = here_q - wa;
      3'd4: there = here_q + wa + AW'(1);
      3'd5: there = here_q + wa - AW'(1);
      3'd6: there = here_q - wa + AW'(1);
      default: there = here_q - wa - AW'(1);
    endcase
  end

  assign drop    = sext_h(h0_q) - sext_h(h_rdata_q);
  assign excess  = drop - signed'(64'(talus_q));
  assign mult    = MultOne + 19'(strength_q);
  assign prod    = 31'(ex_q) * 31'(mult);

  always_comb begin
    move = 12'd0;
    if (moves_q) begin
      if (big_q || (prod[30:16] > 15'(cap_q))) move = cap_q;
      else move = prod[27:16];
    end
  end

  assign rd_ext  = sext_h(h_rdata_q);
  assign rd_word = oor_q ? 32'd0 : rd_ext[31:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    oor_d       = oor_q;
    pass_d      = pass_q;
    w_d         = w_q;
    h_d         = h_q;
    col_d       = col_q;
    row_d       = row_q;
    n_d         = n_q;
    cap_d       = cap_q;
    here_d      = here_q;
    there_d     = there_q;
    apply_d     = apply_q;
    k_d         = k_q;
    h0_d        = h0_q;
    dacc_d      = dacc_q;
    dthere_d    = dthere_q;
    moves_d     = moves_q;
    big_d       = big_q;
    ex_d        = ex_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    h_we        = 1'b0;
    h_waddr     = AW'(in_data_i.cell_index);
    h_wdata     = sat_h(64'(in_data_i.height_in));
    h_raddr     = here_q;
    d_we        = 1'b0;
    d_waddr     = here_q;
    d_wdata     = dacc_q;
    d_raddr     = here_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_data_i.operation)
            OpLoad: begin
              h_we = (32'(in_data_i.cell_index) < 32'(Depth));
            end
            OpRun: begin
              w_d    = w_eff;
              h_d    = h_eff;
              n_d    = (AW + 1)'(w_eff) * (AW + 1)'(h_eff);
              cap_d  = (int'(w_eff) >= LargeGridSide || int'(h_eff) >= LargeGridSide)
                       ? CapLargeGrid : CapSmallGrid;
              pass_d = 8'd0;
              state_d = (pass_count_q == 8'd0) ? StDone : StPStart;
            end
            OpRead: begin
              addr_d  = AW'(in_data_i.cell_index);
              oor_d   = !(32'(in_data_i.cell_index) < 32'(Depth));
              state_d = StRead1;
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        d_we    = 1'b1;
        d_waddr = clr_q;
        d_wdata = 32'd0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) state_d = StIdle;
      end
      StRead1: begin
        h_raddr = addr_q;
        state_d = StRead2;
      end
      StRead2: begin
        h_raddr = addr_q;
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.result_kind      = KindRead;
          out_d.height_out       = signed'(rd_word);
          state_d                = StIdle;
        end
      end
      StPStart: begin
        if (w_q < SW'(3) || h_q < SW'(3)) begin
          state_d = StPEnd;
        end else begin
          here_d  = wa + AW'(1);
          col_d   = SW'(1);
          row_d   = SW'(1);
          state_d = StCell;
        end
      end
      StCell: begin
        state_d = StCellW;
      end
      StCellW: begin
        h0_d    = h_rdata_q;
        dacc_d  = d_rdata_q;
        k_d     = 3'd0;
        state_d = StNb;
      end
      StNb: begin
        h_raddr = there;
        d_raddr = there;
        there_d = there;
        state_d = StNbW;
      end
      StNbW: begin
        dthere_d = d_rdata_q;
        moves_d  = (drop > signed'(64'(talus_q)));
        big_d    = (excess >= signed'(64'(cap_q)));
        ex_d     = excess[11:0];
        state_d  = StNbM;
      end
      StNbM: begin
        d_we    = 1'b1;
        d_waddr = there_q;
        d_wdata = dthere_q + 32'(move);
        dacc_d  = dacc_q - 32'(move);
        if (k_q == k_last) begin
          state_d = StCEnd;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = StNb;
        end
      end
      StCEnd: begin
        d_we    = 1'b1;
        d_waddr = here_q;
        d_wdata = dacc_q;
        if (col_q == w_q - SW'(2)) begin
          if (row_q == h_q - SW'(2)) begin
            apply_d = '0;
            state_d = StApplyR;
          end else begin
            row_d   = row_q + SW'(1);
            col_d   = SW'(1);
            here_d  = here_q + AW'(3);
            state_d = StCell;
          end
        end else begin
          col_d   = col_q + SW'(1);
          here_d  = here_q + AW'(1);
          state_d = StCell;
        end
      end
      StApplyR: begin
        h_raddr = apply_q;
        d_raddr = apply_q;
        state_d = StApplyW;
      end
      StApplyW: begin
        h_we    = 1'b1;
        h_waddr = apply_q;
        h_wdata = sat_h(sext_h(h_rdata_q) + 64'(signed'(d_rdata_q)));
        d_we    = 1'b1;
        d_waddr = apply_q;
        d_wdata = 32'd0;
        if (apply_q == AW'(n_q - (AW + 1)'(1))) begin
          state_d = StPEnd;
        end else begin
          apply_d = apply_q + AW'(1);
          state_d = StApplyR;
        end
      end
      StPEnd: begin
        pass_d  = pass_q + 8'd1;
        state_d = (pass_q + 8'd1 == pass_count_q) ? StDone : StPStart;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = KindDone;
          out_d.height_out  = '0;
          pass_d            = 8'd0;
          state_d           = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    oor_q    <= oor_d;
    w_q      <= w_d;
    h_q      <= h_d;
    col_q    <= col_d;
    row_q    <= row_d;
    n_q      <= n_d;
    cap_q    <= cap_d;
    here_q   <= here_d;
    there_q  <= there_d;
    apply_q  <= apply_d;
    k_q      <= k_d;
    h0_q     <= h0_d;
    dacc_q   <= dacc_d;
    dthere_q <= dthere_d;
    moves_q  <= moves_d;
    big_q    <= big_d;
    ex_q     <= ex_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
